### rtl/core/nge_pkg.sv
// Shared types and constants for the next-greater-element stack core.
// No dependencies; used by the interfaces, the control and the stack memory.
package nge_pkg;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 12;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

	// one stack entry as held in the memory
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
	} entry_t;

	// one result without its end-of-run flag
	typedef struct packed {
		logic [POS_W-1:0]    position;
		logic [VALUE_W-1:0]  answer;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

### rtl/core/nge_in_if.sv
// Input channel of the stack core: one array element per transfer.
// Depends on nge_pkg for field widths.
interface nge_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [nge_pkg::VALUE_W-1:0] value;
	logic                              end_of_array;

	modport source (output valid, value, end_of_array, input ready);
	modport sink (input valid, value, end_of_array, output ready);
endinterface

### rtl/core/nge_out_if.sv
// Result channel of the stack core: one decided position per transfer.
// Depends on nge_pkg for field widths.
interface nge_out_if;
	logic                               valid;
	logic                               ready;
	logic [nge_pkg::POS_W-1:0]          position;
	logic signed [nge_pkg::VALUE_W-1:0] answer;
	logic [nge_pkg::STATUS_W-1:0]       status;
	logic                               last_of_run;

	modport source (output valid, position, answer, status, last_of_run, input ready);
	modport sink (input valid, position, answer, status, last_of_run, output ready);
endinterface

### rtl/core/nge_stack_mem.sv
// Stack storage: one write port, one read port, registered read data.
// Depends on nge_pkg (entry_t).
module nge_stack_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  nge_pkg::entry_t     wr_data,
	input  logic [AW-1:0]       rd_addr,
	output nge_pkg::entry_t     rd_data
);

	nge_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/core/nge_ctrl.sv
// Sequencer for the stack core: pop loop, push, drain, result staging
// and the output register. Depends on nge_pkg and both channel interfaces.
module nge_ctrl #(
	parameter int STACK_DEPTH = 32,
	parameter int MAX_LENGTH  = 4096,
	parameter int AW          = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	nge_in_if.sink           elem,
	nge_out_if.source        result,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output nge_pkg::entry_t  wr_data,
	output logic [AW-1:0]    rd_addr,
	input  nge_pkg::entry_t  rd_data
);

	localparam int PW = $clog2(MAX_LENGTH);
	localparam logic [AW-1:0] FULL     = AW'(STACK_DEPTH - 1);
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_LENGTH - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CMP   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]    state_q, state_d;
	logic [AW-1:0] count_q, count_d;
	logic [PW-1:0] pos_q, pos_d, pos_inc;
	logic signed [nge_pkg::VALUE_W-1:0] v_q;
	logic          last_q;

	logic              pend_valid_q, pend_valid_d;
	nge_pkg::result_t  pend_q, pend_d;
	logic              out_valid_q;
	nge_pkg::result_t  out_q;
	logic              out_last_q;

	logic              emit, emit_last, out_free, pop, accept;
	nge_pkg::result_t  emit_res;
	logic [nge_pkg::POS_W-1:0] pos12;

	assign accept   = elem.valid && elem.ready;
	assign out_free = !out_valid_q || result.ready;
	assign pos12    = nge_pkg::POS_W'(pos_q);
	assign pos_inc  = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
	assign pop      = (count_q != '0) && ($signed(rd_data.value) < v_q);

	assign elem.ready         = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.position    = out_q.position;
	assign result.answer      = out_q.answer;
	assign result.status      = out_q.status;
	assign result.last_of_run = out_last_q;

	// the read port always fetches the top of the stack as it will be next cycle
	assign rd_addr = count_d - 1'b1;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		pos_d        = pos_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		emit         = 1'b0;
		emit_last    = 1'b0;
		emit_res     = pend_q;
		wr_en        = 1'b0;
		wr_addr      = count_q;
		wr_data      = '{value: v_q, position: pos12};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (pop) begin
					// staged one deep: whether a pop is final is known only later
					if (!pend_valid_q || out_free) begin
						emit         = pend_valid_q;
						pend_d       = '{position: rd_data.position, answer: v_q,
						                 status: nge_pkg::ST_FOUND};
						pend_valid_d = 1'b1;
						count_d      = count_q - 1'b1;
					end
				end else if (pend_valid_q) begin
					if (out_free) begin
						emit         = 1'b1;
						emit_last    = !last_q;
						pend_valid_d = 1'b0;
						if (!last_q) begin
							wr_en   = 1'b1;
							count_d = count_q + 1'b1;
							pos_d   = pos_inc;
							state_d = S_IDLE;
						end
					end
				end else if (last_q) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_res  = '{position: pos12, answer: '0, status: nge_pkg::ST_NONE};
						emit_last = (count_q == '0);
						if (count_q == '0) begin
							pos_d   = '0;
							state_d = S_IDLE;
						end else begin
							state_d = S_DRAIN;
						end
					end
				end else if (count_q == FULL) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_res  = '{position: pos12, answer: '0, status: nge_pkg::ST_DROPPED};
						emit_last = 1'b1;
						pos_d     = pos_inc;
						state_d   = S_IDLE;
					end
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
					pos_d   = pos_inc;
					state_d = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_res  = '{position: rd_data.position, answer: '0,
					              status: nge_pkg::ST_NONE};
					emit_last = (count_q == AW'(1));
					count_d   = count_q - 1'b1;
					if (count_q == AW'(1)) begin
						pos_d   = '0;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pos_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			pos_q        <= pos_d;
			pend_valid_q <= pend_valid_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= elem.value;
			last_q <= elem.end_of_array;
		end
		pend_q <= pend_d;
		if (emit) begin
			out_q      <= emit_res;
			out_last_q <= emit_last;
		end
	end

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q < FULL))
		else $error("push into a full stack");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("staged result left behind at end of item");

	a_drain_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (last_q && count_q != '0))
		else $error("drain without a last element or with an empty stack");

	a_array_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_IDLE) && last_q) ##1 (state_q == S_IDLE)
		|-> (count_q == '0 && pos_q == '0))
		else $error("stack or position not cleared after last element");
`endif

endmodule

### rtl/core/next_greater_element_stack_core.sv
// Next-greater-element core on a monotonic stack.
// Channel elem: one signed 32-bit array element per transfer, end_of_array on
// the final one. Channel result: one decided position per transfer with its
// answer, a status (greater found, no greater, dropped) and last_of_run on the
// final result caused by an element.
// Timing: elem.ready is high only while no element is in work. An element
// pops one entry per compare; an element that pops or drops shows its last
// result through the output register once it has been decided. The last
// element of an array then reports itself as having no greater element and
// drains every entry left on the stack, one result per entry.
// The pop loop is bounded by the stack memory's registered read: each compare
// uses the top entry that the read port fetched ahead of it.
// A result waiting in the output register does not block the next element;
// a stalled receiver holds the pop and drain loops until the register frees.
// Up to STACK_DEPTH-1 entries are held; a non-final element that finds the
// stack full is reported as dropped. Positions count modulo MAX_LENGTH.
// Reset empties the stack and zeroes the position counter at once; the
// memory itself is not cleared, since only entries below the count are read.
// Depends on nge_pkg, nge_in_if, nge_out_if, nge_stack_mem, nge_ctrl.
module next_greater_element_stack_core #(
	parameter int STACK_DEPTH = 32,
	parameter int MAX_LENGTH  = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	nge_in_if.sink    elem,
	nge_out_if.source result
);

	localparam int AW = $clog2(STACK_DEPTH);

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	nge_pkg::entry_t  wr_data;
	nge_pkg::entry_t  rd_data;

	nge_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_LENGTH  (MAX_LENGTH),
		.AW          (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.elem    (elem),
		.result  (result),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nge_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
